/* rtl/dlp_pkg.sv */
// ----------------------------------------------------------------------------
// Duration list parser package
// Character codes, field widths and the token control group shared by the
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dlp_pkg;

    localparam int MINUTE_WIDTH_DEF = 16;
    localparam int SEC_W            = 7;
    localparam int DUR_W            = 22;
    localparam int CHAR_W           = 8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Control group that goes with one character through the parser.
    typedef struct packed {
        logic has_result;  // this character closes a result beat
        logic dur_ok;      // the closed token is valid and nonzero
        logic list_end;    // the character was the last of the list
    } t_tok_ctl;

endpackage

`default_nettype wire

/* rtl/dlp_token_fsm.sv */
// ----------------------------------------------------------------------------
// Duration list parser token state machine
// Holds the token phase and the minute and second accumulators, and works out
// in one step what a character does to them and whether it closes a token.
// ----------------------------------------------------------------------------
`default_nettype none

module dlp_token_fsm #(
    parameter int MINUTE_WIDTH = dlp_pkg::MINUTE_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_beat_valid,
    input  wire logic                       i_advance,
    input  wire logic [dlp_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                       i_end_of_list,
    output dlp_pkg::t_tok_ctl               o_ctl,
    output logic [MINUTE_WIDTH-1:0]         o_minutes,
    output logic [dlp_pkg::SEC_W-1:0]       o_seconds
);
    import dlp_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_MIN   = 4'd1;
    localparam logic [3:0] PH_COLON = 4'd2;
    localparam logic [3:0] PH_SEC1  = 4'd3;
    localparam logic [3:0] PH_SEC2  = 4'd4;
    localparam logic [3:0] PH_DOT   = 4'd5;
    localparam logic [3:0] PH_FRAC1 = 4'd6;
    localparam logic [3:0] PH_FRAC2 = 4'd7;
    localparam logic [3:0] PH_FRAC3 = 4'd8;
    localparam logic [3:0] PH_BAD   = 4'd9;

    localparam int WIDE_W = MINUTE_WIDTH + 4;
    localparam logic [MINUTE_WIDTH-1:0] MIN_MAX = {MINUTE_WIDTH{1'b1}};

    logic [3:0]              r_phase,   n_phase;
    logic [MINUTE_WIDTH-1:0] r_minutes, n_minutes;
    logic [SEC_W-1:0]        r_seconds, n_seconds;

    logic                    take;
    logic                    digit;
    logic [3:0]              d;
    logic [3:0]              t_phase;
    logic [MINUTE_WIDTH-1:0] t_minutes;
    logic [SEC_W-1:0]        t_seconds;
    logic [WIDE_W-1:0]       min_ext;
    logic [WIDE_W-1:0]       min_wide;
    logic [SEC_W-1:0]        sec_next;
    logic                    ending;
    logic                    ok;
    logic                    nonzero;

    always_comb begin
        take     = (i_char_code != CHAR_SPACE);
        digit    = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
        d        = digit ? i_char_code[3:0] : 4'd0;
        min_ext  = {4'd0, r_minutes};
        // minutes * 10 + digit; saturates when it passes the all-ones value
        min_wide = (min_ext << 3) + (min_ext << 1) + {{(WIDE_W-4){1'b0}}, d};
        sec_next = (r_seconds << 3) + (r_seconds << 1) + {{(SEC_W-4){1'b0}}, d};

        t_phase   = r_phase;
        t_minutes = r_minutes;
        t_seconds = r_seconds;
        if (take) begin
            case (r_phase)
                PH_IDLE: begin
                    if (digit) begin
                        t_minutes = {{(MINUTE_WIDTH-4){1'b0}}, d};
                        t_seconds = '0;
                        t_phase   = PH_MIN;
                    end else begin
                        t_phase = PH_BAD;
                    end
                end
                PH_MIN: begin
                    if (digit) begin
                        if (min_wide > {4'd0, MIN_MAX}) begin
                            t_minutes = MIN_MAX;
                        end else begin
                            t_minutes = min_wide[MINUTE_WIDTH-1:0];
                        end
                    end else if (i_char_code == CHAR_COLON) begin
                        t_phase = PH_COLON;
                    end else begin
                        t_phase = PH_BAD;
                    end
                end
                PH_COLON: begin
                    if (digit) begin
                        t_seconds = {{(SEC_W-4){1'b0}}, d};
                        t_phase   = PH_SEC1;
                    end else begin
                        t_phase = PH_BAD;
                    end
                end
                PH_SEC1: begin
                    if (digit) begin
                        t_seconds = sec_next;
                        t_phase   = PH_SEC2;
                    end else begin
                        t_phase = PH_BAD;
                    end
                end
                PH_SEC2:  t_phase = (i_char_code == CHAR_DOT) ? PH_DOT : PH_BAD;
                PH_DOT:   t_phase = digit ? PH_FRAC1 : PH_BAD;
                PH_FRAC1: t_phase = digit ? PH_FRAC2 : PH_BAD;
                PH_FRAC2: t_phase = digit ? PH_FRAC3 : PH_BAD;
                default:  t_phase = PH_BAD;
            endcase
        end

        ending  = !take || i_end_of_list;
        ok      = (t_phase == PH_SEC2) || (t_phase == PH_FRAC1) ||
                  (t_phase == PH_FRAC2) || (t_phase == PH_FRAC3);
        nonzero = ok && ((t_minutes != '0) || (t_seconds != '0));

        o_ctl.has_result = i_beat_valid && (i_end_of_list || (ending && nonzero));
        o_ctl.dur_ok     = nonzero;
        o_ctl.list_end   = i_end_of_list;
        o_minutes        = nonzero ? t_minutes : '0;
        o_seconds        = nonzero ? t_seconds : '0;

        if (ending) begin
            n_phase   = PH_IDLE;
            n_minutes = '0;
            n_seconds = '0;
        end else begin
            n_phase   = t_phase;
            n_minutes = t_minutes;
            n_seconds = t_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_minutes <= '0;
            r_seconds <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
        end
    end

endmodule

`default_nettype wire

/* rtl/dlp_dur_calc.sv */
// ----------------------------------------------------------------------------
// Duration list parser seconds calculation
// Turns a registered minute and second count into minutes*60+seconds,
// kept to the width of the result field.
// ----------------------------------------------------------------------------
`default_nettype none

module dlp_dur_calc #(
    parameter int MINUTE_WIDTH = dlp_pkg::MINUTE_WIDTH_DEF
) (
    input  wire logic [MINUTE_WIDTH-1:0]   i_minutes,
    input  wire logic [dlp_pkg::SEC_W-1:0] i_seconds,
    output logic [dlp_pkg::DUR_W-1:0]      o_duration_seconds
);
    import dlp_pkg::*;

    localparam int SUM_W = (MINUTE_WIDTH + 6 > DUR_W) ? MINUTE_WIDTH + 6 : DUR_W;

    logic [SUM_W-1:0] min_ext;
    logic [SUM_W-1:0] total;

    always_comb begin
        min_ext = {{(SUM_W-MINUTE_WIDTH){1'b0}}, i_minutes};
        // 60 * m = 64 * m - 4 * m
        total   = (min_ext << 6) - (min_ext << 2) +
                  {{(SUM_W-SEC_W){1'b0}}, i_seconds};
        o_duration_seconds = total[DUR_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/duration_list_parser_unit.sv */
// ----------------------------------------------------------------------------
// Duration list parser
// Reads a space-separated list of m:ss[.fff] durations one character per
// beat and gives the length of each valid, nonzero token in seconds.
// ----------------------------------------------------------------------------
// The block takes one Latin-1 character per input beat and keeps up with a
// new character in every clock cycle while no result waits on a stalled
// output. A character goes into an input register, the state machine works
// out from there what it does to the token, and any result is written into
// an output register at the clock on which that character moves on. A
// result beat is produced when a space closes a valid token whose value is
// nonzero, and always on the character flagged as the end of the list, where
// o_list_end is high and o_duration_valid tells whether the final token
// counted. Characters that produce no result never wait for the output
// register, so stalls on the output only hold up the input when a result
// really has to be stored. Minutes saturate at the all-ones value of
// MINUTE_WIDTH bits and the reported total is kept to 22 bits. There are no
// registers to configure.
// ----------------------------------------------------------------------------
`default_nettype none

module duration_list_parser_unit #(
    parameter int MINUTE_WIDTH = dlp_pkg::MINUTE_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [dlp_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                       i_end_of_list,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [dlp_pkg::DUR_W-1:0]       o_duration_seconds,
    output logic                            o_duration_valid,
    output logic                            o_list_end
);
    import dlp_pkg::*;

    // Input register: holds the character beat that is being parsed.
    logic                    r_in_valid, n_in_valid;
    logic [CHAR_W-1:0]       r_in_char;
    logic                    r_in_last;

    // Output register: the waiting result beat.
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_ok;
    logic                    r_out_last;
    logic [MINUTE_WIDTH-1:0] r_out_min;
    logic [SEC_W-1:0]        r_out_sec;

    t_tok_ctl                tok_ctl;
    logic [MINUTE_WIDTH-1:0] tok_min;
    logic [SEC_W-1:0]        tok_sec;
    logic                    out_free;
    logic                    can_go;
    logic                    in_accept;
    logic                    load_out;

    dlp_token_fsm #(
        .MINUTE_WIDTH (MINUTE_WIDTH)
    ) u_token_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat_valid  (r_in_valid),
        .i_advance     (can_go),
        .i_char_code   (r_in_char),
        .i_end_of_list (r_in_last),
        .o_ctl         (tok_ctl),
        .o_minutes     (tok_min),
        .o_seconds     (tok_sec)
    );

    // The output slot is free when empty or when its beat leaves this cycle.
    // A held character moves on when it needs no slot, or when one is free.
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        can_go     = r_in_valid && (!tok_ctl.has_result || out_free);
        load_out   = can_go && tok_ctl.has_result;
        o_in_stall = r_in_valid && !can_go;
        in_accept  = i_in_valid && !o_in_stall;

        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (can_go) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_end_of_list;
        end
        if (load_out) begin
            r_out_ok   <= tok_ctl.dur_ok;
            r_out_last <= tok_ctl.list_end;
            r_out_min  <= tok_min;
            r_out_sec  <= tok_sec;
        end
    end

    dlp_dur_calc #(
        .MINUTE_WIDTH (MINUTE_WIDTH)
    ) u_dur_calc (
        .i_minutes          (r_out_min),
        .i_seconds          (r_out_sec),
        .o_duration_seconds (o_duration_seconds)
    );

    assign o_out_valid      = r_out_valid;
    assign o_duration_valid = r_out_ok;
    assign o_list_end       = r_out_last;

    // A counted duration is never zero before scaling.
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok) |-> ((r_out_min != '0) || (r_out_sec != '0)))
        else $error("counted duration with zero minutes and seconds");

    // The last character of a list always leaves a closing result beat.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (can_go && r_in_last) |=> (r_out_valid && r_out_last))
        else $error("end of list produced no closing result");

    // The input side only stalls while a character is held.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && tok_ctl.has_result && r_out_valid))
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

/* tb/sv/duration_list_parser_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Duration list parser unit test
// Feeds character beats into the parser and checks every result beat field
// by field. The expected beats come from a model of the token state machine
// kept in this bench, or from the directed table where a row gives its own.
// A short table of directed characters runs first. After it comes a long
// run of random lists, made mostly of well-formed m:ss[.fff] tokens with
// some broken tokens and noise mixed in. Both sides idle in random bursts.
// ----------------------------------------------------------------------------

module duration_list_parser_unit_test;
    import dlp_pkg::*;

    localparam int     MIN_W         = MINUTE_WIDTH_DEF;
    localparam longint MIN_SAT       = (longint'(1) << MIN_W) - 1;
    localparam int     HALF_PERIOD   = 6;
    localparam int     RESET_CYCLES  = 6;
    localparam int     DIRECTED_ROWS = 25;
    localparam int     RANDOM_ITEMS  = 1650;
    localparam int     CALM_ITEMS    = 200;
    localparam int     IDLE_LIMIT    = 4000;
    localparam int     DRAIN_CYCLES  = 10;

    // Where the parser stands inside the current token.
    typedef enum logic [3:0] {
        TOK_IDLE,
        TOK_MINUTES,
        TOK_AFTER_COLON,
        TOK_SEC_ONE,
        TOK_SEC_TWO,
        TOK_AFTER_DOT,
        TOK_FRAC_ONE,
        TOK_FRAC_TWO,
        TOK_FRAC_THREE,
        TOK_INVALID
    } tok_phase_t;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [DUR_W-1:0] secs;
        logic             dur_ok;
        logic             list_end;
    } dur_beat_t;

    // One character beat of stimulus. When typed is set, the row closes a
    // result and want holds that result, written out by hand.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              typed;
        dur_beat_t         want;
    } char_row_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic [CHAR_W-1:0]   char_code      = '0;
    logic                end_of_list    = 1'b0;
    logic                out_stall      = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [DUR_W-1:0]    duration_seconds;
    logic                duration_valid;
    logic                list_end;

    // The bench's own copy of the parser state.
    tok_phase_t          tok_phase      = TOK_IDLE;
    longint              minutes        = 0;
    logic [SEC_W-1:0]    seconds        = '0;

    dur_beat_t           pending_durations [$];
    char_row_t           char_stream [$];
    int                  mismatch_count = 0;
    int                  idle_cycles    = 0;
    bit                  calm           = 1'b0;

    // Directed characters, walked in order straight after reset.
    char_row_t directed_rows [DIRECTED_ROWS] = '{
        // A lone space that ends the list gives an empty, invalid close.
        '{CHAR_SPACE, 1'b1, 1'b1, '{22'd0, 1'b0, 1'b1}},
        // 99999:99 pushes the minutes into saturation and gives the
        // largest total the block can report.
        '{"9",        1'b0, 1'b0, '0},
        '{"9",        1'b0, 1'b0, '0},
        '{"9",        1'b0, 1'b0, '0},
        '{"9",        1'b0, 1'b0, '0},
        '{"9",        1'b0, 1'b0, '0},
        '{CHAR_COLON, 1'b0, 1'b0, '0},
        '{"9",        1'b0, 1'b0, '0},
        '{"9",        1'b0, 1'b0, '0},
        '{CHAR_SPACE, 1'b0, 1'b1, '{22'd3932199, 1'b1, 1'b0}},
        // A second space makes an empty token, which is skipped.
        '{CHAR_SPACE, 1'b0, 1'b0, '0},
        // 0:00 is well formed but zero, so the space gives no beat.
        '{"0",        1'b0, 1'b0, '0},
        '{CHAR_COLON, 1'b0, 1'b0, '0},
        '{"0",        1'b0, 1'b0, '0},
        '{"0",        1'b0, 1'b0, '0},
        '{CHAR_SPACE, 1'b0, 1'b0, '0},
        // 1:00.1234 has a fourth fraction digit, so the list closes on an
        // invalid token.
        '{"1",        1'b0, 1'b0, '0},
        '{CHAR_COLON, 1'b0, 1'b0, '0},
        '{"0",        1'b0, 1'b0, '0},
        '{"0",        1'b0, 1'b0, '0},
        '{CHAR_DOT,   1'b0, 1'b0, '0},
        '{"1",        1'b0, 1'b0, '0},
        '{"2",        1'b0, 1'b0, '0},
        '{"3",        1'b0, 1'b0, '0},
        '{"4",        1'b1, 1'b1, '{22'd0, 1'b0, 1'b1}}
    };

    duration_list_parser_unit u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_char_code        (char_code),
        .i_end_of_list      (end_of_list),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_duration_seconds (duration_seconds),
        .o_duration_valid   (duration_valid),
        .o_list_end         (list_end)
    );

    always begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Takes one character into the token model. It returns 1 when the
    // character closes a result beat, and the beat comes back in beat.
    function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic last,
                                      output dur_beat_t beat);
        bit          is_digit;
        longint      d;
        longint      sec_next;
        logic [63:0] total;
        bit          closed_ok;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d        = is_digit ? longint'(c - CHAR_ZERO) : 0;
        beat     = '0;
        if (c != CHAR_SPACE) begin
            case (tok_phase)
                TOK_IDLE: begin
                    if (is_digit) begin
                        minutes   = d;
                        seconds   = '0;
                        tok_phase = TOK_MINUTES;
                    end else begin
                        tok_phase = TOK_INVALID;
                    end
                end
                TOK_MINUTES: begin
                    if (is_digit) begin
                        // The minutes stick at all ones once they would overflow.
                        if (minutes > (MIN_SAT - d) / 10)
                            minutes = MIN_SAT;
                        else
                            minutes = minutes * 10 + d;
                    end else if (c == CHAR_COLON) begin
                        tok_phase = TOK_AFTER_COLON;
                    end else begin
                        tok_phase = TOK_INVALID;
                    end
                end
                TOK_AFTER_COLON: begin
                    if (is_digit) begin
                        seconds   = d[SEC_W-1:0];
                        tok_phase = TOK_SEC_ONE;
                    end else begin
                        tok_phase = TOK_INVALID;
                    end
                end
                TOK_SEC_ONE: begin
                    if (is_digit) begin
                        sec_next  = longint'(seconds) * 10 + d;
                        seconds   = sec_next[SEC_W-1:0];
                        tok_phase = TOK_SEC_TWO;
                    end else begin
                        tok_phase = TOK_INVALID;
                    end
                end
                TOK_SEC_TWO:    tok_phase = (c == CHAR_DOT) ? TOK_AFTER_DOT : TOK_INVALID;
                TOK_AFTER_DOT:  tok_phase = is_digit ? TOK_FRAC_ONE : TOK_INVALID;
                TOK_FRAC_ONE:   tok_phase = is_digit ? TOK_FRAC_TWO : TOK_INVALID;
                TOK_FRAC_TWO:   tok_phase = is_digit ? TOK_FRAC_THREE : TOK_INVALID;
                default:        tok_phase = TOK_INVALID;
            endcase
            if (!last)
                return 1'b0;
        end
        // The token closes here, either on a space or on the last character.
        closed_ok = (tok_phase == TOK_SEC_TWO) || (tok_phase == TOK_FRAC_ONE) ||
                    (tok_phase == TOK_FRAC_TWO) || (tok_phase == TOK_FRAC_THREE);
        total     = closed_ok ? 64'(minutes * 60 + longint'(seconds)) : 64'd0;
        tok_phase = TOK_IDLE;
        minutes   = 0;
        seconds   = '0;
        if (!last && total == 0)
            return 1'b0;
        beat.secs     = total[DUR_W-1:0];
        beat.dur_ok   = (total != 0);
        beat.list_end = last;
        return 1'b1;
    endfunction

    function automatic void add_char(input logic [CHAR_W-1:0] c, input logic last);
        char_row_t r;
        r.code  = c;
        r.last  = last;
        r.typed = 1'b0;
        r.want  = '0;
        char_stream.push_back(r);
    endfunction

    // Zero comes up more often than the other digits, so that zero-valued
    // tokens are not rare.
    function automatic logic [CHAR_W-1:0] random_digit();
        if ($urandom_range(0, 3) == 0)
            return CHAR_ZERO;
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Appends one random token and what follows it. Most tokens are well
    // formed. Some are broken by a stray byte, a dropped character or an
    // extra digit, and the rest are raw noise. About one token in sixteen
    // ends the list.
    task automatic add_token();
        logic [CHAR_W-1:0] tok [$];
        int                kind;
        int                n;
        int                pos;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
            repeat (n) tok.push_back(random_digit());
            tok.push_back(CHAR_COLON);
            tok.push_back(random_digit());
            tok.push_back(random_digit());
            if ($urandom_range(0, 1) == 1) begin
                tok.push_back(CHAR_DOT);
                repeat ($urandom_range(1, 3)) tok.push_back(random_digit());
            end
            if (kind >= 70) begin
                pos = $urandom_range(0, tok.size() - 1);
                case ($urandom_range(0, 2))
                    0:       tok[pos] = 8'($urandom_range(0, 255));
                    1:       tok.delete(pos);
                    default: tok.push_back(random_digit());
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 4)) tok.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 15) == 0) begin
            // The list sometimes ends on a trailing space.
            if ($urandom_range(0, 3) == 0)
                tok.push_back(CHAR_SPACE);
            foreach (tok[i]) add_char(tok[i], i == tok.size() - 1);
        end else begin
            foreach (tok[i]) add_char(tok[i], 1'b0);
            repeat ($urandom_range(1, 3)) add_char(CHAR_SPACE, 1'b0);
        end
    endtask

    // Input side. Each character beat is held until it is accepted. Valid
    // drops only for an idle burst, and never within the same step in which
    // it is raised again.
    initial begin
        char_row_t row;
        dur_beat_t beat;
        bit        has_beat;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            char_stream.push_back(directed_rows[i]);
        while (char_stream.size() < DIRECTED_ROWS + RANDOM_ITEMS)
            add_token();
        // Close the final list so that the last token is flushed out.
        char_stream[char_stream.size() - 1].last = 1'b1;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (char_stream[i]) begin
            row  = char_stream[i];
            calm = (i >= char_stream.size() - CALM_ITEMS);
            if (!calm && $urandom_range(0, 5) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            in_valid    <= 1'b1;
            char_code   <= row.code;
            end_of_list <= row.last;
            do @(posedge clk); while (in_stall);
            // The beat was taken at this edge, so the model moves on.
            has_beat = parse_char(row.code, row.last, beat);
            if (has_beat)
                pending_durations.push_back(row.typed ? row.want : beat);
            @(negedge clk);
        end
        in_valid <= 1'b0;

        while (pending_durations.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("duration_list_parser_unit_test: clean");
        else
            $display("duration_list_parser_unit_test: errors");
        $finish;
    end

    // Output side. The stall comes in random bursts, and no new burst starts
    // during the calm tail of the run.
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge clk);
            if (burst == 0 && !calm && $urandom_range(0, 7) == 0)
                burst = $urandom_range(1, 11);
            if (burst > 0) begin
                out_stall <= 1'b1;
                burst--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Each accepted result beat is checked against the oldest expected beat.
    always @(posedge clk) begin : result_check
        dur_beat_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_durations.size() == 0) begin
                $display("%0t: result beat with none expected: secs %0d valid %0b end %0b",
                         $time, duration_seconds, duration_valid, list_end);
                mismatch_count++;
            end else begin
                want = pending_durations.pop_front();
                if (duration_seconds !== want.secs) begin
                    $display("%0t: duration_seconds expected %0d, actual %0d",
                             $time, want.secs, duration_seconds);
                    mismatch_count++;
                end
                if (duration_valid !== want.dur_ok) begin
                    $display("%0t: duration_valid expected %0b, actual %0b",
                             $time, want.dur_ok, duration_valid);
                    mismatch_count++;
                end
                if (list_end !== want.list_end) begin
                    $display("%0t: list_end expected %0b, actual %0b",
                             $time, want.list_end, list_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: the run ends if no beat moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("duration_list_parser_unit_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
